/* design/drect_pkg.sv */
package drect_pkg;

	// Item kinds carried in the kind field
	typedef enum logic [1:0] {
		KIND_MARK      = 2'd0,
		KIND_MARK_ALL  = 2'd1,
		KIND_FLIP      = 2'd2,
		KIND_FLIP_FULL = 2'd3
	} kind_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_ENABLED       = 2'd0;
	localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd2;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int COORD_W     = 16;
	localparam int RECT_W      = 18;

	localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'd1920;
	localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'd1080;

	// Rectangle after clipping to the screen; edges valid only when not empty
	typedef struct packed {
		logic               empty;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} clip_rect_t;

endpackage

/* design/drect_in_if.sv */
interface drect_in_if import drect_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               kind;
	logic signed [RECT_W-1:0] rect_x;
	logic signed [RECT_W-1:0] rect_y;
	logic signed [RECT_W-1:0] rect_w;
	logic signed [RECT_W-1:0] rect_h;

	modport source (output valid, kind, rect_x, rect_y, rect_w, rect_h, input ready);
	modport sink (input valid, kind, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

/* design/drect_out_if.sv */
interface drect_out_if import drect_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] present_x;
	logic [COORD_W-1:0] present_y;
	logic [COORD_W-1:0] present_w;
	logic [COORD_W-1:0] present_h;

	modport source (output valid, present_x, present_y, present_w, present_h, input ready);
	modport sink (input valid, present_x, present_y, present_w, present_h, output ready);
endinterface

/* design/drect_clip.sv */
module drect_clip import drect_pkg::*; (
	input  logic signed [RECT_W-1:0] rect_x,
	input  logic signed [RECT_W-1:0] rect_y,
	input  logic signed [RECT_W-1:0] rect_w,
	input  logic signed [RECT_W-1:0] rect_h,
	input  logic [COORD_W-1:0]       screen_width,
	input  logic [COORD_W-1:0]       screen_height,
	output clip_rect_t               clip
);

	logic signed [RECT_W:0] x1, y1, x2_raw, y2_raw, x2, y2, sw, sh;

	// Far edges (exclusive), one bit wider to hold the sum
	assign x2_raw = {rect_x[RECT_W-1], rect_x} + {rect_w[RECT_W-1], rect_w};
	assign y2_raw = {rect_y[RECT_W-1], rect_y} + {rect_h[RECT_W-1], rect_h};
	assign sw     = signed'({{(RECT_W+1-COORD_W){1'b0}}, screen_width});
	assign sh     = signed'({{(RECT_W+1-COORD_W){1'b0}}, screen_height});

	// Raise near edges to zero, lower far edges to the screen size
	assign x1 = rect_x[RECT_W-1] ? '0 : {1'b0, rect_x};
	assign y1 = rect_y[RECT_W-1] ? '0 : {1'b0, rect_y};
	assign x2 = (x2_raw > sw) ? sw : x2_raw;
	assign y2 = (y2_raw > sh) ? sh : y2_raw;

	// When not empty all edges lie within [0, screen size]
	assign clip.empty  = (x1 >= x2) || (y1 >= y2);
	assign clip.left   = x1[COORD_W-1:0];
	assign clip.top    = y1[COORD_W-1:0];
	assign clip.right  = x2[COORD_W-1:0];
	assign clip.bottom = y2[COORD_W-1:0];

endmodule

/* design/drect_box.sv */
module drect_box import drect_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  logic [1:0]         kind_s1,
	input  clip_rect_t         clip,
	input  logic               enabled,
	input  logic [COORD_W-1:0] screen_width,
	input  logic [COORD_W-1:0] screen_height,
	input  logic               out_ready,
	output logic               done_s1,
	output logic               out_valid,
	output logic [COORD_W-1:0] present_x,
	output logic [COORD_W-1:0] present_y,
	output logic [COORD_W-1:0] present_w,
	output logic [COORD_W-1:0] present_h
);

	logic               box_valid_q;
	logic [COORD_W-1:0] box_left_q, box_top_q, box_right_q, box_bottom_q;
	logic               out_valid_q;
	logic [COORD_W-1:0] px_q, py_q, pw_q, ph_q;

	logic need_out, stall, mark_hit;

	// A flip needs the result register; other kinds never wait
	assign need_out = enabled && (kind_s1 == KIND_FLIP || kind_s1 == KIND_FLIP_FULL);
	assign stall    = valid_s1 && need_out && out_valid_q && !out_ready;
	assign done_s1  = valid_s1 && !stall;
	assign mark_hit = enabled && kind_s1 == KIND_MARK && !clip.empty;

	// Box state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_valid_q  <= 1'b0;
			box_left_q   <= '0;
			box_top_q    <= '0;
			box_right_q  <= '0;
			box_bottom_q <= '0;
		end else if (done_s1 && enabled) begin
			case (kind_s1)
				KIND_MARK: begin
					if (!clip.empty) begin
						box_valid_q <= 1'b1;
						if (!box_valid_q || clip.left < box_left_q)
							box_left_q <= clip.left;
						if (!box_valid_q || clip.top < box_top_q)
							box_top_q <= clip.top;
						if (!box_valid_q || clip.right > box_right_q)
							box_right_q <= clip.right;
						if (!box_valid_q || clip.bottom > box_bottom_q)
							box_bottom_q <= clip.bottom;
					end
				end
				KIND_MARK_ALL: begin
					box_valid_q  <= 1'b1;
					box_left_q   <= '0;
					box_top_q    <= '0;
					box_right_q  <= screen_width;
					box_bottom_q <= screen_height;
				end
				default: begin
					box_valid_q <= 1'b0;
				end
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done_s1 && need_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done_s1 && need_out) begin
			if (kind_s1 == KIND_FLIP && box_valid_q) begin
				px_q <= box_left_q;
				py_q <= box_top_q;
				pw_q <= box_right_q - box_left_q;
				ph_q <= box_bottom_q - box_top_q;
			end else begin
				px_q <= '0;
				py_q <= '0;
				pw_q <= screen_width;
				ph_q <= screen_height;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign present_x = px_q;
	assign present_y = py_q;
	assign present_w = pw_q;
	assign present_h = ph_q;

	// Checks
	a_flip_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && need_out |=> out_valid_q)
		else $error("flip did not load a result");

	a_flip_clears_box: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && need_out |=> !box_valid_q)
		else $error("flip left the box marked");

	a_mark_sets_box: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 && mark_hit |=> box_valid_q)
		else $error("visible mark did not set the box");

	a_box_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		box_valid_q |-> (box_left_q <= box_right_q) && (box_top_q <= box_bottom_q))
		else $error("box edges out of order");

endmodule

/* design/dirty_rect_accumulator.sv */
// Dirty-rectangle accumulator.
// in_ch (valid/ready) takes one request per cycle unless stalled: kind selects
// mark rectangle, mark whole screen, flip, or flip full; rect_* give origin and
// signed size. out_ch (valid/ready) gives one request per flip or flip-full:
// the region to present as x, y, width, height. Mark requests give no result.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 enabled,
// 1 screen width, 2 screen height) at a rising edge; write only while idle.
// Path: an accepted request is worked on in the input register, and a flip's
// result is then loaded from there into the output register, which drives
// out_ch. Throughput: one request per cycle while no flip stalls, set by the
// single input register feeding the box update and the result register.
// Stall: when the result register is full and out_ch is not taken, a flip
// waits in the input register and in_ch drops ready; marks pass on freely.
// Reset (arst_n low): box cleared, block disabled, screen 1920 x 1080, both
// channels empty. While disabled every request is taken and dropped.
module dirty_rect_accumulator import drect_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	drect_in_if.sink               in_ch,
	drect_out_if.source            out_ch,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic                     enabled_q;
	logic [COORD_W-1:0]       screen_width_q, screen_height_q;
	logic                     valid_s1;
	logic [1:0]               kind_s1;
	logic signed [RECT_W-1:0] rect_x_s1, rect_y_s1, rect_w_s1, rect_h_s1;
	logic                     done_s1;
	clip_rect_t               clip;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= 1'b0;
			screen_width_q  <= SCREEN_WIDTH_RST;
			screen_height_q <= SCREEN_HEIGHT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ENABLED:       enabled_q       <= cfg_data[0];
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data[COORD_W-1:0];
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	assign in_ch.ready = !valid_s1 || done_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1   <= in_ch.kind;
			rect_x_s1 <= in_ch.rect_x;
			rect_y_s1 <= in_ch.rect_y;
			rect_w_s1 <= in_ch.rect_w;
			rect_h_s1 <= in_ch.rect_h;
		end
	end

	drect_clip u_clip (
		.rect_x        (rect_x_s1),
		.rect_y        (rect_y_s1),
		.rect_w        (rect_w_s1),
		.rect_h        (rect_h_s1),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.clip          (clip)
	);

	drect_box u_box (
		.clk           (clk),
		.arst_n        (arst_n),
		.valid_s1      (valid_s1),
		.kind_s1       (kind_s1),
		.clip          (clip),
		.enabled       (enabled_q),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.out_ready     (out_ch.ready),
		.done_s1       (done_s1),
		.out_valid     (out_ch.valid),
		.present_x     (out_ch.present_x),
		.present_y     (out_ch.present_y),
		.present_w     (out_ch.present_w),
		.present_h     (out_ch.present_h)
	);

endmodule
